>>> rtl/core/amrd_pkg.sv
// ----------------------------------------------------------------------------
// amrd_pkg
// Shared types and constants for the audio module reply deframer.
// ----------------------------------------------------------------------------
package amrd_pkg;

    localparam int unsigned TIMER_BITS = 10;
    localparam int unsigned CFG_BITS   = 10;
    localparam int unsigned FRAME_LEN  = 10;
    localparam int unsigned CNT_BITS   = $clog2(FRAME_LEN + 1);

    typedef logic [7:0]            t_byte;
    typedef logic [TIMER_BITS-1:0] t_timer;
    typedef logic [CFG_BITS-1:0]   t_cfg;
    typedef logic [CNT_BITS-1:0]   t_count;

    localparam t_cfg   TIMEOUT_RESET = t_cfg'(10);
    localparam t_timer TIMER_MAX     = '1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] OUT_GOOD    = 2'd0;
    localparam logic [1:0] OUT_BAD     = 2'd1;
    localparam logic [1:0] OUT_TIMEOUT = 2'd2;

    localparam logic [2:0] ST_STOPPED  = 3'd0;
    localparam logic [2:0] ST_PLAYING  = 3'd1;
    localparam logic [2:0] ST_PAUSED   = 3'd2;
    localparam logic [2:0] ST_SLEEPING = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;

    localparam t_byte HDR_START   = 8'h7E;
    localparam t_byte HDR_VERSION = 8'hFF;
    localparam t_byte HDR_LENGTH  = 8'h06;
    localparam t_byte TRL_END     = 8'hEF;
    localparam t_byte CMD_STATUS  = 8'h42;
    localparam t_byte CMD_COUNT   = 8'h48;

    localparam t_byte RAW_STOPPED  = 8'h00;
    localparam t_byte RAW_PLAYING  = 8'h01;
    localparam t_byte RAW_PAUSED   = 8'h02;
    localparam t_byte RAW_SLEEPING = 8'h08;

    function automatic logic [2:0] decode_status(input t_byte b);
        logic [2:0] s;
        case (b)
            RAW_STOPPED:  s = ST_STOPPED;
            RAW_PLAYING:  s = ST_PLAYING;
            RAW_PAUSED:   s = ST_PAUSED;
            RAW_SLEEPING: s = ST_SLEEPING;
            default:      s = ST_UNKNOWN;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/core/audio_module_reply_deframer.sv
// ----------------------------------------------------------------------------
// audio_module_reply_deframer
// Collects ten-byte reply frames from a serial audio player and reports them.
// ----------------------------------------------------------------------------
// Usage: each input request carries either a received UART byte or a
// one-millisecond tick, selected by i_opcode. Ten bytes make a frame, which
// is checked for its header and trailer and reported as one output request
// with the command code, the parameter and the decoded playback status.
// A partial frame that sees no byte for the configured number of ticks is
// dropped and reported as a timeout. Other ticks and bytes give no output.
// The timeout register is written through its own valid/ready channel,
// which is always ready; it must only be written while the block is idle.
// A result appears in the output register in the cycle after the request
// that caused it. One request is taken every cycle while the output
// register is empty or being drained in the same cycle.
// When the receiver stalls, the held result keeps o_in_ready low and no
// further requests are taken. Reset empties the frame, disarms the timer,
// clears the detected flag, empties the output and sets the timeout to 10.
// ----------------------------------------------------------------------------
module audio_module_reply_deframer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_opcode,
    input  amrd_pkg::t_byte       i_rx_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_outcome,
    output amrd_pkg::t_byte       o_command_code,
    output logic [15:0]           o_parameter_res,
    output logic [2:0]            o_play_status,
    output logic                  o_status_reported,
    output logic                  o_count_reported,
    output logic                  o_detected,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  amrd_pkg::t_cfg        i_cfg_timeout_ticks
);
    import amrd_pkg::*;

    t_byte       r_frame [FRAME_LEN];
    t_count      r_count,   n_count;
    t_timer      r_timer,   n_timer;
    logic        r_armed,   n_armed;
    logic        r_seen,    n_seen;
    t_cfg        r_timeout;

    logic        r_out_valid;
    logic [1:0]  r_outcome,  n_outcome;
    t_byte       r_cmd,      n_cmd;
    logic [15:0] r_param,    n_param;
    logic [2:0]  r_status,   n_status;
    logic        r_st_rep,   n_st_rep;
    logic        r_cnt_rep,  n_cnt_rep;
    logic        r_det,      n_det;

    logic        accept;
    logic        has_result;
    t_count      wr_idx;
    t_timer      tick_timer;
    logic        timed_out;
    logic        good;
    logic [2:0]  dec_status;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign wr_idx     = (r_count >= t_count'(FRAME_LEN)) ? '0 : r_count;
    assign tick_timer = (r_timer == TIMER_MAX) ? r_timer : r_timer + t_timer'(1);
    assign timed_out  = ({6'd0, tick_timer} >= {6'd0, r_timeout}) ||
                        (tick_timer == TIMER_MAX);
    assign good       = (r_frame[0] == HDR_START) && (r_frame[1] == HDR_VERSION) &&
                        (r_frame[2] == HDR_LENGTH) && (i_rx_byte == TRL_END);
    assign dec_status = decode_status(r_frame[6]);

    always_comb begin
        n_count    = r_count;
        n_timer    = r_timer;
        n_armed    = r_armed;
        n_seen     = r_seen;
        has_result = 1'b0;
        n_outcome  = OUT_TIMEOUT;
        n_cmd      = '0;
        n_param    = '0;
        n_status   = ST_UNKNOWN;
        n_st_rep   = 1'b0;
        n_cnt_rep  = 1'b0;
        n_det      = r_seen;
        if (i_opcode == OP_TICK) begin
            if (r_armed) begin
                n_timer = tick_timer;
                if (timed_out) begin
                    n_count    = '0;
                    n_timer    = '0;
                    n_armed    = 1'b0;
                    has_result = 1'b1;
                end
            end
        end else if (wr_idx != t_count'(FRAME_LEN - 1)) begin
            n_count = wr_idx + t_count'(1);
            n_armed = 1'b1;
            n_timer = '0;
        end else begin
            n_count    = '0;
            n_armed    = 1'b0;
            n_timer    = '0;
            n_seen     = 1'b1;
            has_result = 1'b1;
            n_outcome  = good ? OUT_GOOD : OUT_BAD;
            n_cmd      = r_frame[3];
            n_param    = {r_frame[5], r_frame[6]};
            n_det      = 1'b1;
            if (good && (r_frame[3] == CMD_STATUS)) begin
                n_status = dec_status;
                n_st_rep = (dec_status != ST_UNKNOWN);
            end
            n_cnt_rep = good && (r_frame[3] == CMD_COUNT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_timer     <= '0;
            r_armed     <= 1'b0;
            r_seen      <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_timeout_ticks;
            end
            if (accept) begin
                r_count <= n_count;
                r_timer <= n_timer;
                r_armed <= n_armed;
                r_seen  <= n_seen;
            end
            r_out_valid <= (accept && has_result) || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_opcode == OP_BYTE)) begin
            r_frame[wr_idx[CNT_BITS-1:0]] <= i_rx_byte;
        end
        if (accept && has_result) begin
            r_outcome <= n_outcome;
            r_cmd     <= n_cmd;
            r_param   <= n_param;
            r_status  <= n_status;
            r_st_rep  <= n_st_rep;
            r_cnt_rep <= n_cnt_rep;
            r_det     <= n_det;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_outcome         = r_outcome;
    assign o_command_code    = r_cmd;
    assign o_parameter_res   = r_param;
    assign o_play_status     = r_status;
    assign o_status_reported = r_st_rep;
    assign o_count_reported  = r_cnt_rep;
    assign o_detected        = r_det;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < t_count'(FRAME_LEN))
        else $error("frame byte count out of range");

    a_armed_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed == (r_count != '0))
        else $error("timer arming disagrees with partial frame");

    a_timeout_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_outcome == OUT_TIMEOUT)) |->
            (o_command_code == '0 && o_parameter_res == '0 &&
             !o_status_reported && !o_count_reported))
        else $error("timeout result carries frame fields");

    a_status_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status_reported) |->
            (o_play_status != ST_UNKNOWN && o_outcome == OUT_GOOD))
        else $error("status reported without a known status");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && has_result) |=> o_out_valid)
        else $error("result lost after accepted request");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the audio module reply deframer.
// ----------------------------------------------------------------------------
// Byte and tick requests are driven into the block while a predictor of the
// block's behavior tracks the frame under assembly, the idle timer and the
// detected flag. Every reply is compared field by field with the oldest
// predicted one. Traffic is mostly well-formed reply frames with random
// content, mixed with broken headers, partial frames and stray ticks. The
// timeout register is swept over zero, one, the largest value and others.
// ----------------------------------------------------------------------------
module testbench;
    import amrd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  outcome;
        t_byte       command_code;
        logic [15:0] parameter_res;
        logic [2:0]  play_status;
        logic        status_reported;
        logic        count_reported;
        logic        detected;
    } t_reply;

    typedef t_byte t_frame [FRAME_LEN];

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_opcode;
    t_byte       i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_outcome;
    t_byte       o_command_code;
    logic [15:0] o_parameter_res;
    logic [2:0]  o_play_status;
    logic        o_status_reported;
    logic        o_count_reported;
    logic        o_detected;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg        i_cfg_timeout_ticks;

    t_byte       frame_bytes [FRAME_LEN];
    logic [3:0]  fill_count  = '0;
    t_timer      idle_ticks  = '0;
    logic        armed       = 1'b0;
    logic        seen_frame  = 1'b0;
    t_cfg        timeout_cfg = TIMEOUT_RESET;

    t_reply      pending_replies [$];
    int          fault_count  = 0;
    int          useful_items = 0;
    int          cycle_count  = 0;
    bit          steady       = 1'b0;

    audio_module_reply_deframer u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_opcode            (i_opcode),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_outcome           (o_outcome),
        .o_command_code      (o_command_code),
        .o_parameter_res     (o_parameter_res),
        .o_play_status       (o_play_status),
        .o_status_reported   (o_status_reported),
        .o_count_reported    (o_count_reported),
        .o_detected          (o_detected),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_timeout_ticks (i_cfg_timeout_ticks)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL audio_module_reply_deframer");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (steady) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 17);
        end
    end

    function automatic logic [2:0] raw_to_status(input t_byte raw);
        if (raw == RAW_STOPPED) return ST_STOPPED;
        if (raw == RAW_PLAYING) return ST_PLAYING;
        if (raw == RAW_PAUSED) return ST_PAUSED;
        if (raw == RAW_SLEEPING) return ST_SLEEPING;
        return ST_UNKNOWN;
    endfunction

    // Returns 0 when the request is a tick that the block ignores.
    function automatic bit deframe_step(input logic op, input t_byte b);
        t_reply r;
        logic   frame_ok;
        r = '0;
        if (op == OP_TICK) begin
            if (!armed) return 1'b0;
            if (idle_ticks != TIMER_MAX) idle_ticks++;
            if (idle_ticks >= timeout_cfg || idle_ticks == TIMER_MAX) begin
                fill_count      = '0;
                idle_ticks      = '0;
                armed           = 1'b0;
                r.outcome       = OUT_TIMEOUT;
                r.play_status   = ST_UNKNOWN;
                r.detected      = seen_frame;
                pending_replies = {pending_replies, r};
            end
            return 1'b1;
        end
        if (fill_count >= FRAME_LEN) fill_count = '0;
        frame_bytes[fill_count] = b;
        fill_count++;
        if (fill_count < FRAME_LEN) begin
            armed      = 1'b1;
            idle_ticks = '0;
            return 1'b1;
        end
        seen_frame = 1'b1;
        armed      = 1'b0;
        idle_ticks = '0;
        fill_count = '0;
        frame_ok = frame_bytes[0] == HDR_START && frame_bytes[1] == HDR_VERSION &&
                   frame_bytes[2] == HDR_LENGTH && frame_bytes[9] == TRL_END;
        r.outcome       = frame_ok ? OUT_GOOD : OUT_BAD;
        r.command_code  = frame_bytes[3];
        r.parameter_res = {frame_bytes[5], frame_bytes[6]};
        r.play_status   = ST_UNKNOWN;
        if (frame_ok && frame_bytes[3] == CMD_STATUS) begin
            r.play_status     = raw_to_status(frame_bytes[6]);
            r.status_reported = (r.play_status != ST_UNKNOWN);
        end
        r.count_reported = frame_ok && frame_bytes[3] == CMD_COUNT;
        r.detected       = 1'b1;
        pending_replies  = {pending_replies, r};
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("ERROR %s: got %0h, expected %0h", what, got, want);
        fault_count++;
    endtask

    task automatic check_reply();
        t_reply want;
        if (pending_replies.size() == 0) begin
            report_mismatch("reply with nothing expected", 16'(o_command_code), 16'h0);
            return;
        end
        want = pending_replies.pop_front();
        if (o_outcome !== want.outcome)
            report_mismatch("outcome", 16'(o_outcome), 16'(want.outcome));
        if (o_command_code !== want.command_code)
            report_mismatch("command_code", 16'(o_command_code),
                            16'(want.command_code));
        if (o_parameter_res !== want.parameter_res)
            report_mismatch("parameter_res", o_parameter_res, want.parameter_res);
        if (o_play_status !== want.play_status)
            report_mismatch("play_status", 16'(o_play_status),
                            16'(want.play_status));
        if (o_status_reported !== want.status_reported)
            report_mismatch("status_reported", 16'(o_status_reported),
                            16'(want.status_reported));
        if (o_count_reported !== want.count_reported)
            report_mismatch("count_reported", 16'(o_count_reported),
                            16'(want.count_reported));
        if (o_detected !== want.detected)
            report_mismatch("detected", 16'(o_detected), 16'(want.detected));
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_reply();
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_item(input logic op, input t_byte b);
        while (!steady && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_rx_byte  <= b;
        do @(negedge i_clk); while (!o_in_ready);
        if (deframe_step(op, b)) useful_items++;
        @(posedge i_clk);
    endtask

    task automatic send_byte(input t_byte b);
        send_item(OP_BYTE, b);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, t_byte'($urandom));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_timeout(input t_cfg value);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_timeout_ticks <= value;
        do @(negedge i_clk); while (!o_cfg_ready);
        timeout_cfg = value;
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_byte mostly(input t_byte want);
        return ($urandom_range(99) < 90) ? want : t_byte'($urandom);
    endfunction

    task automatic traffic_burst();
        t_frame f;
        int     pick;
        int     n;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 3) wait_drained();
        if (pick < 70) begin
            while (fill_count != 0) send_byte(t_byte'($urandom));
            f[0] = mostly(HDR_START);
            f[1] = mostly(HDR_VERSION);
            f[2] = mostly(HDR_LENGTH);
            n = $urandom_range(99);
            f[3] = (n < 40) ? CMD_STATUS : (n < 60) ? CMD_COUNT : t_byte'($urandom);
            f[4] = t_byte'($urandom);
            f[5] = t_byte'($urandom);
            case ($urandom_range(4))
                0:       f[6] = RAW_STOPPED;
                1:       f[6] = RAW_PLAYING;
                2:       f[6] = RAW_PAUSED;
                3:       f[6] = RAW_SLEEPING;
                default: f[6] = t_byte'($urandom);
            endcase
            f[7] = t_byte'($urandom);
            f[8] = t_byte'($urandom);
            f[9] = mostly(TRL_END);
            for (int i = 0; i < FRAME_LEN; i++) begin
                if (i > 0 && $urandom_range(99) < ((timeout_cfg > 3) ? 10 : 2)) begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_tick();
                end
                send_byte(f[i]);
            end
        end else if (pick < 80) begin
            n = $urandom_range(1, FRAME_LEN - 1);
            for (int i = 0; i < n; i++) send_byte((i == 0) ? HDR_START : t_byte'($urandom));
            if (timeout_cfg <= 40) begin
                while (armed) send_tick();
            end
        end else if (pick < 90) begin
            n = $urandom_range(1, 3);
            repeat (n) send_tick();
        end else begin
            n = $urandom_range(1, 5);
            repeat (n) send_byte(t_byte'($urandom));
        end
    endtask

    task automatic test_directed();
        t_frame f;
        f = '{HDR_START, HDR_VERSION, HDR_LENGTH, CMD_STATUS, 8'h00,
              8'hFF, RAW_SLEEPING, 8'h00, 8'hFF, TRL_END};
        foreach (f[i]) send_byte(f[i]);
        send_tick();
        wait_drained();
        @(posedge i_clk);
        send_byte(HDR_START);
        send_byte(HDR_VERSION);
        send_byte(HDR_LENGTH);
        while (armed) send_tick();
    endtask

    // A long timeout keeps the partial frame alive for many ticks.
    task automatic test_long_timeout();
        write_timeout(t_cfg'(200));
        send_byte(HDR_START);
        while (armed) send_tick();
    endtask

    task automatic test_random_traffic(input t_cfg tmo, input int count, input bit no_idle);
        int start;
        write_timeout(tmo);
        steady = no_idle;
        start  = useful_items;
        while (useful_items - start < count) traffic_burst();
        wait_drained();
        steady = 1'b0;
    endtask

    initial begin
        foreach (frame_bytes[i]) frame_bytes[i] = '0;
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_opcode            <= OP_BYTE;
        i_rx_byte           <= '0;
        i_cfg_valid         <= 1'b0;
        i_cfg_timeout_ticks <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_long_timeout();
        test_random_traffic(t_cfg'(0), 80, 1'b0);
        test_random_traffic(t_cfg'(1), 80, 1'b0);
        test_random_traffic(t_cfg'(TIMER_MAX), 100, 1'b0);
        test_random_traffic(t_cfg'(3), 110, 1'b1);
        test_random_traffic(t_cfg'($urandom_range(2, 30)), 110, 1'b0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (pending_replies.size() != 0)
            report_mismatch("replies never seen", 16'h0, 16'(pending_replies.size()));
        if (fault_count == 0) begin
            $display("PASS audio_module_reply_deframer");
        end else begin
            $display("FAIL audio_module_reply_deframer");
        end
        $finish;
    end

endmodule
